// ===== rtl/sgpo_pkg.sv =====
// Shared types and constants of the segment/polygon occlusion block.
package sgpo_pkg;

  // Default coordinate width (signed Q12.4)
  localparam int unsigned COORD_BITS_DEF = 16;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_X = 2'd0,
    CFG_START_Y = 2'd1,
    CFG_END_X   = 2'd2,
    CFG_END_Y   = 2'd3
  } sgpo_cfg_idx_e;

  // Product compares per edge: four orientations plus the parity crossing.
  // Compare k uses product 2k on the left and product 2k+1 on the right.
  localparam int unsigned NUM_CMP  = 5;
  localparam int unsigned NUM_PROD = 2 * NUM_CMP;
  localparam int unsigned CMP_O1   = 0;  // start vs edge
  localparam int unsigned CMP_O2   = 1;  // end vs edge
  localparam int unsigned CMP_O3   = 2;  // edge start vs sight
  localparam int unsigned CMP_O4   = 3;  // edge end vs sight
  localparam int unsigned CMP_TOG  = 4;  // ray parity crossing

  // Polygon count saturates here; an obstacle needs this many vertices to block
  localparam logic [1:0] FULL_COUNT = 2'd3;

  // Per-vertex control carried down the pipe
  typedef struct packed {
    logic poly_last;
    logic query_last;
    logic has_prev;
    logic full;
  } sgpo_ctrl_t;

  // Parity-test side flags of one edge
  typedef struct packed {
    logic tog_cond;
    logic den_pos;
  } sgpo_edge_flags_t;

endpackage

// ===== rtl/sgpo_front.sv =====
// Input stage: vertex tracking (first, previous, count) and the stage-1 register.
module sgpo_front
  import sgpo_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] vert_x_i,
  input  logic signed [COORD_BITS-1:0] vert_y_i,
  input  logic                         poly_last_i,
  input  logic                         query_last_i,
  input  logic                         s2_free_i,
  output logic                         s1_adv_o,
  output logic signed [COORD_BITS-1:0] cur_x_o,
  output logic signed [COORD_BITS-1:0] cur_y_o,
  output logic signed [COORD_BITS-1:0] prev_x_o,
  output logic signed [COORD_BITS-1:0] prev_y_o,
  output logic signed [COORD_BITS-1:0] first_x_o,
  output logic signed [COORD_BITS-1:0] first_y_o,
  output sgpo_ctrl_t                   ctrl_o
);

  logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [1:0]                   cnt_q, cnt_d;
  logic                         v1_q;
  logic                         accept;
  logic                         has_prev;
  sgpo_ctrl_t                   ctrl_d;

  assign in_ready_o = !v1_q || s2_free_i;
  assign s1_adv_o   = v1_q && s2_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign has_prev   = (cnt_q != 2'd0);

  always_comb begin
    if (poly_last_i) begin
      cnt_d = 2'd0;
    end else if (cnt_q == FULL_COUNT) begin
      cnt_d = FULL_COUNT;
    end else begin
      cnt_d = cnt_q + 2'd1;
    end
    ctrl_d.poly_last  = poly_last_i;
    ctrl_d.query_last = query_last_i;
    ctrl_d.has_prev   = has_prev;
    ctrl_d.full       = (cnt_q >= (FULL_COUNT - 2'd1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      v1_q  <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        v1_q <= 1'b1;
      end else if (s1_adv_o) begin
        v1_q <= 1'b0;
      end
    end
  end

  // Vertex history and stage-1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_x_q  <= vert_x_i;
      prev_y_q  <= vert_y_i;
      cur_x_o   <= vert_x_i;
      cur_y_o   <= vert_y_i;
      prev_x_o  <= prev_x_q;
      prev_y_o  <= prev_y_q;
      ctrl_o    <= ctrl_d;
      if (has_prev) begin
        first_x_o <= first_x_q;
        first_y_o <= first_y_q;
      end else begin
        first_x_q <= vert_x_i;
        first_y_q <= vert_y_i;
        first_x_o <= vert_x_i;
        first_y_o <= vert_y_i;
      end
    end
  end

endmodule

// ===== rtl/sgpo_edge_prod.sv =====
// Product stage of one polygon edge: all cross products, registered.
module sgpo_edge_prod
  import sgpo_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned DW = COORD_BITS + 1,
  localparam int unsigned PW = 2 * DW
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [COORD_BITS-1:0] q_x_i,
  input  logic signed [COORD_BITS-1:0] q_y_i,
  input  logic signed [COORD_BITS-1:0] r_x_i,
  input  logic signed [COORD_BITS-1:0] r_y_i,
  input  logic signed [COORD_BITS-1:0] s_x_i,
  input  logic signed [COORD_BITS-1:0] s_y_i,
  input  logic signed [COORD_BITS-1:0] e_x_i,
  input  logic signed [COORD_BITS-1:0] e_y_i,
  output logic signed [PW-1:0]         prod_o [NUM_PROD],
  output sgpo_edge_flags_t             flags_o
);

  logic signed [DW-1:0] qx_sx, qy_sy, rx_sx, ry_sy;
  logic signed [DW-1:0] qx_ex, qy_ey, rx_ex, ry_ey;
  logic signed [DW-1:0] ex_sx, ey_sy;
  logic signed [DW-1:0] qx_rx, sy_ry, sx_rx, qy_ry;
  logic signed [PW-1:0] prod_d [NUM_PROD];
  sgpo_edge_flags_t     flags_d;

  always_comb begin
    qx_sx = DW'(q_x_i) - DW'(s_x_i);
    qy_sy = DW'(q_y_i) - DW'(s_y_i);
    rx_sx = DW'(r_x_i) - DW'(s_x_i);
    ry_sy = DW'(r_y_i) - DW'(s_y_i);
    qx_ex = DW'(q_x_i) - DW'(e_x_i);
    qy_ey = DW'(q_y_i) - DW'(e_y_i);
    rx_ex = DW'(r_x_i) - DW'(e_x_i);
    ry_ey = DW'(r_y_i) - DW'(e_y_i);
    ex_sx = DW'(e_x_i) - DW'(s_x_i);
    ey_sy = DW'(e_y_i) - DW'(s_y_i);
    qx_rx = DW'(q_x_i) - DW'(r_x_i);
    sy_ry = DW'(s_y_i) - DW'(r_y_i);
    sx_rx = DW'(s_x_i) - DW'(r_x_i);
    qy_ry = DW'(q_y_i) - DW'(r_y_i);

    prod_d[2*CMP_O1]    = PW'(ry_sy) * PW'(qx_sx);
    prod_d[2*CMP_O1+1]  = PW'(qy_sy) * PW'(rx_sx);
    prod_d[2*CMP_O2]    = PW'(ry_ey) * PW'(qx_ex);
    prod_d[2*CMP_O2+1]  = PW'(qy_ey) * PW'(rx_ex);
    prod_d[2*CMP_O3]    = PW'(qy_sy) * PW'(ex_sx);
    prod_d[2*CMP_O3+1]  = PW'(ey_sy) * PW'(qx_sx);
    prod_d[2*CMP_O4]    = PW'(ry_sy) * PW'(ex_sx);
    prod_d[2*CMP_O4+1]  = PW'(ey_sy) * PW'(rx_sx);
    // ray parity: division by (qy - ry) replaced by cross-multiplication
    prod_d[2*CMP_TOG]   = PW'(qx_rx) * PW'(sy_ry);
    prod_d[2*CMP_TOG+1] = PW'(sx_rx) * PW'(qy_ry);

    flags_d.tog_cond = (r_y_i > s_y_i) != (q_y_i > s_y_i);
    flags_d.den_pos  = (q_y_i > r_y_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o  <= prod_d;
      flags_o <= flags_d;
    end
  end

endmodule

// ===== rtl/sgpo_back.sv =====
// Compare stage: edge tests, polygon accumulation and the result register.
module sgpo_back
  import sgpo_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned PW = 2 * (COORD_BITS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s1_adv_i,
  input  sgpo_ctrl_t           ctrl_i,
  output logic                 s2_free_o,
  input  logic signed [PW-1:0] e1_prod_i [NUM_PROD],
  input  sgpo_edge_flags_t     e1_flags_i,
  input  logic signed [PW-1:0] e2_prod_i [NUM_PROD],
  input  sgpo_edge_flags_t     e2_flags_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 obstacle_blocked_o,
  output logic                 sight_clear_o,
  output logic                 query_done_o
);

  logic              v2_q;
  sgpo_ctrl_t        ctrl2_q;
  logic              hit_q, par_q, qblk_q;
  logic              out_free, adv2;
  logic [NUM_CMP-1:0] gt1, gt2;
  logic              tog_rev1, tog_rev2;
  logic              cross1, cross2, tog1, tog2;
  logic              hit_n, par_n, hit_f, par_f, blocked, qblk_n;

  assign out_free  = !out_valid_o || out_ready_i;
  assign adv2      = v2_q && (!ctrl2_q.poly_last || out_free);
  assign s2_free_o = !v2_q || adv2;

  always_comb begin
    for (int k = 0; k < NUM_CMP; k++) begin
      gt1[k] = e1_prod_i[2*k] > e1_prod_i[2*k+1];
      gt2[k] = e2_prod_i[2*k] > e2_prod_i[2*k+1];
    end
    tog_rev1 = e1_prod_i[2*CMP_TOG+1] > e1_prod_i[2*CMP_TOG];
    tog_rev2 = e2_prod_i[2*CMP_TOG+1] > e2_prod_i[2*CMP_TOG];

    cross1 = (gt1[CMP_O1] != gt1[CMP_O2]) && (gt1[CMP_O3] != gt1[CMP_O4]);
    cross2 = (gt2[CMP_O1] != gt2[CMP_O2]) && (gt2[CMP_O3] != gt2[CMP_O4]);
    // reverse the compare when the edge's y-difference is negative
    tog1 = e1_flags_i.tog_cond && (e1_flags_i.den_pos ? gt1[CMP_TOG] : tog_rev1);
    tog2 = e2_flags_i.tog_cond && (e2_flags_i.den_pos ? gt2[CMP_TOG] : tog_rev2);

    hit_n   = hit_q || (ctrl2_q.has_prev && cross1);
    par_n   = par_q ^ (ctrl2_q.has_prev && tog1);
    hit_f   = hit_n || cross2;
    par_f   = par_n ^ tog2;
    blocked = ctrl2_q.full && (hit_f || par_f);
    qblk_n  = qblk_q || blocked;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      hit_q       <= 1'b0;
      par_q       <= 1'b0;
      qblk_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (s1_adv_i) begin
        v2_q <= 1'b1;
      end else if (adv2) begin
        v2_q <= 1'b0;
      end

      if (adv2 && ctrl2_q.poly_last) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end

      if (adv2) begin
        if (ctrl2_q.poly_last) begin
          hit_q  <= 1'b0;
          par_q  <= 1'b0;
          qblk_q <= ctrl2_q.query_last ? 1'b0 : qblk_n;
        end else begin
          hit_q <= hit_n;
          par_q <= par_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_i) begin
      ctrl2_q <= ctrl_i;
    end
    if (adv2 && ctrl2_q.poly_last) begin
      obstacle_blocked_o <= blocked;
      sight_clear_o      <= !qblk_n;
      query_done_o       <= ctrl2_q.query_last;
    end
  end

endmodule

// ===== rtl/segment_polygon_occlusion.sv =====
// Top level of the segment/polygon line-of-sight occlusion block.
//
// Tests one sight segment, held in four configuration registers, against a
// stream of polygon obstacles given one vertex per request. Each closed edge
// (consecutive vertices, then the last back to the first) gets the strict
// orientation crossing test against the segment and the even-odd ray test of
// the start point; an obstacle of three or more vertices blocks when any edge
// crosses or the start lies inside. One result comes out per obstacle, on its
// last vertex; the last obstacle of a query raises query_done with the overall
// sight_clear flag. All tests are exact on signed Q12.4 coordinates. The block
// takes one vertex per cycle while the result output is not held back. A result
// passes the input register, the product register and the result register in
// that order, and stays at the outputs until out_ready_i takes it. The rate is
// set by the product stage: both edges a vertex may close are evaluated at once
// by ten parallel products each, so no vertex ever reuses a unit. Configuration
// writes are always taken; write them only while no request is in flight.
module segment_polygon_occlusion
  import sgpo_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  // vertex requests
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] vert_x_i,
  input  logic signed [COORD_BITS-1:0] vert_y_i,
  input  logic                         poly_last_i,
  input  logic                         query_last_i,
  // obstacle results
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         obstacle_blocked_o,
  output logic                         sight_clear_o,
  output logic                         query_done_o
);

  localparam int unsigned PW = 2 * (COORD_BITS + 1);

  logic signed [COORD_BITS-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic                         cfg_we;

  logic                         s1_adv, s2_free;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, prev_x, prev_y, first_x, first_y;
  sgpo_ctrl_t                   ctrl1;

  logic signed [PW-1:0]         e1_prod [NUM_PROD];
  logic signed [PW-1:0]         e2_prod [NUM_PROD];
  sgpo_edge_flags_t             e1_flags, e2_flags;

  // Configuration: always ready, one register per index
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
    end else if (cfg_we) begin
      unique case (sgpo_cfg_idx_e'(cfg_index_i))
        CFG_START_X: start_x_q <= cfg_data_i;
        CFG_START_Y: start_y_q <= cfg_data_i;
        CFG_END_X:   end_x_q   <= cfg_data_i;
        CFG_END_Y:   end_y_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Stage 1: register the vertex along with its predecessor and the first one
  sgpo_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .vert_x_i     (vert_x_i),
    .vert_y_i     (vert_y_i),
    .poly_last_i  (poly_last_i),
    .query_last_i (query_last_i),
    .s2_free_i    (s2_free),
    .s1_adv_o     (s1_adv),
    .cur_x_o      (cur_x),
    .cur_y_o      (cur_y),
    .prev_x_o     (prev_x),
    .prev_y_o     (prev_y),
    .first_x_o    (first_x),
    .first_y_o    (first_y),
    .ctrl_o       (ctrl1)
  );

  // Stage 2: products of the edge previous -> current
  sgpo_edge_prod #(
    .COORD_BITS(COORD_BITS)
  ) u_edge_open (
    .clk_i   (clk_i),
    .en_i    (s1_adv),
    .q_x_i   (prev_x),
    .q_y_i   (prev_y),
    .r_x_i   (cur_x),
    .r_y_i   (cur_y),
    .s_x_i   (start_x_q),
    .s_y_i   (start_y_q),
    .e_x_i   (end_x_q),
    .e_y_i   (end_y_q),
    .prod_o  (e1_prod),
    .flags_o (e1_flags)
  );

  // Stage 2: products of the closing edge current -> first (used on the last vertex)
  sgpo_edge_prod #(
    .COORD_BITS(COORD_BITS)
  ) u_edge_close (
    .clk_i   (clk_i),
    .en_i    (s1_adv),
    .q_x_i   (cur_x),
    .q_y_i   (cur_y),
    .r_x_i   (first_x),
    .r_y_i   (first_y),
    .s_x_i   (start_x_q),
    .s_y_i   (start_y_q),
    .e_x_i   (end_x_q),
    .e_y_i   (end_y_q),
    .prod_o  (e2_prod),
    .flags_o (e2_flags)
  );

  // Stage 3: compare, accumulate per polygon and per query, hold the result
  sgpo_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s1_adv_i           (s1_adv),
    .ctrl_i             (ctrl1),
    .s2_free_o          (s2_free),
    .e1_prod_i          (e1_prod),
    .e1_flags_i         (e1_flags),
    .e2_prod_i          (e2_prod),
    .e2_flags_i         (e2_flags),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .obstacle_blocked_o (obstacle_blocked_o),
    .sight_clear_o      (sight_clear_o),
    .query_done_o       (query_done_o)
  );

endmodule
